>>> sv/stq_pkg.sv
package stq_pkg;

  localparam int unsigned QueueDepthDefault = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CANCEL = 2'd1,
    OP_POP    = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_PAST  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  timer_id;
    logic [63:0] expiry_time;
    logic [31:0] period;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  popped_id;
    logic [63:0] popped_time;
    logic [63:0] now_time;
  } rsp_t;

  // One queue slot as it is stored in the memory.
  typedef struct packed {
    logic [63:0] slot_time;
    logic [7:0]  slot_ident;
    logic [31:0] slot_period;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_CAN_RD,
    ST_CAN_CMP,
    ST_POP_RD,
    ST_POP_CAP,
    ST_SH_CHK,
    ST_SH_WR,
    ST_FIN
  } state_e;

endpackage

>>> sv/stq_ram.sv
module stq_ram #(
  parameter int unsigned Depth = stq_pkg::QueueDepthDefault,
  parameter int unsigned Aw    = $clog2(Depth)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [Aw-1:0]   waddr_i,
  input  stq_pkg::entry_t wdata_i,
  input  logic [Aw-1:0]   raddr_i,
  output stq_pkg::entry_t rdata_o
);
  import stq_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/sorted_timer_queue.sv
// Channel   Direction  Handshake               Payload
// request   in         in_valid_i / in_ready_o  req_i  (stq_pkg::req_t)
// response  out        out_valid_o / out_ready_i rsp_o (stq_pkg::rsp_t)
//
// One request is handled at a time; a new request is taken only in the idle
// state. Shifts go through the single memory port pair, one slot at a time:
// each slot is read, then written one place up or down. Insert moves later
// slots up and writes the new timer in the gap, or in slot zero. Cancel
// probes slots for the identifier and pulls later slots down over a match.
// Pop pulls slots down and puts a periodic timer back through the insert
// path. Rejected and no-op requests go straight to the response.
// Reset clears the fill count, the current time and the control state; slot
// contents need no clearing. A stalled response holds in the output register.
module sorted_timer_queue #(
  parameter int unsigned QUEUE_DEPTH = stq_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  stq_pkg::req_t req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output stq_pkg::rsp_t rsp_o
);
  import stq_pkg::*;

  localparam int unsigned Aw = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned Cw = $clog2(QUEUE_DEPTH + 1);
  localparam logic [Cw-1:0] DepthC = Cw'(QUEUE_DEPTH);

  state_e state_q, state_d;
  req_t   req_q, req_d;
  entry_t new_q, new_d;
  logic [Cw-1:0] count_q, count_d;
  logic [63:0]   now_q, now_d;
  logic [Aw-1:0] idx_q, idx_d;
  logic [1:0]    status_q, status_d;
  logic [7:0]    pid_q, pid_d;
  logic [63:0]   ptime_q, ptime_d;
  logic          reinsert_q, reinsert_d;
  logic          is_pop_q, is_pop_d;
  logic          out_valid_q, out_valid_d;
  rsp_t          rsp_q, rsp_d;

  logic          we;
  logic [Aw-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  logic [64:0]   next_time;
  logic [Cw-1:0] idx_ext, idx_inc;
  logic [Cw-1:0] count_dec;

  stq_ram #(
    .Depth (QUEUE_DEPTH),
    .Aw    (Aw)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign idx_ext   = Cw'(idx_q);
  assign idx_inc   = idx_ext + Cw'(1);
  assign count_dec = count_q - Cw'(1);
  assign next_time = {1'b0, rdata.slot_time} + {33'd0, rdata.slot_period};

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    new_d       = new_q;
    count_d     = count_q;
    now_d       = now_q;
    idx_d       = idx_q;
    status_d    = status_q;
    pid_d       = pid_q;
    ptime_d     = ptime_q;
    reinsert_d  = reinsert_q;
    is_pop_d    = is_pop_q;
    out_valid_d = out_valid_q;
    rsp_d       = rsp_q;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = new_q;
    raddr       = idx_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d      = req_i;
          status_d   = STATUS_OK;
          pid_d      = '0;
          ptime_d    = '0;
          reinsert_d = 1'b0;
          is_pop_d   = 1'b0;
          idx_d      = '0;
          new_d      = '{slot_time: req_i.expiry_time, slot_ident: req_i.timer_id,
                         slot_period: req_i.period};
          state_d    = ST_FIN;
          case (req_i.opcode)
            OP_INSERT: begin
              if (req_i.expiry_time < now_q) begin
                status_d = STATUS_PAST;
              end else if (count_q >= DepthC) begin
                status_d = STATUS_FULL;
              end else if (count_q == '0) begin
                state_d = ST_INS_PUT;
              end else begin
                idx_d   = Aw'(count_dec);
                state_d = ST_INS_RD;
              end
            end
            OP_CANCEL: begin
              if (count_q == '0) begin
                status_d = STATUS_EMPTY;
              end else begin
                state_d = ST_CAN_RD;
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                status_d = STATUS_EMPTY;
              end else begin
                is_pop_d = 1'b1;
                state_d  = ST_POP_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_INS_RD: begin
        raddr   = idx_q;
        state_d = ST_INS_CMP;
      end

      ST_INS_CMP: begin
        // Slots later than the new timer move up one place.
        we    = 1'b1;
        waddr = Aw'(idx_inc);
        if (rdata.slot_time > new_q.slot_time) begin
          wdata = rdata;
          if (idx_q == '0) begin
            state_d = ST_INS_PUT;
          end else begin
            idx_d   = idx_q - Aw'(1);
            state_d = ST_INS_RD;
          end
        end else begin
          wdata   = new_q;
          count_d = count_q + Cw'(1);
          state_d = ST_FIN;
        end
      end

      ST_INS_PUT: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = new_q;
        count_d = count_q + Cw'(1);
        state_d = ST_FIN;
      end

      ST_CAN_RD: begin
        raddr   = idx_q;
        state_d = ST_CAN_CMP;
      end

      ST_CAN_CMP: begin
        if (rdata.slot_ident == req_q.timer_id) begin
          state_d = ST_SH_CHK;
        end else if (idx_inc >= count_q) begin
          state_d = ST_FIN;
        end else begin
          idx_d   = Aw'(idx_inc);
          state_d = ST_CAN_RD;
        end
      end

      ST_POP_RD: begin
        raddr   = '0;
        state_d = ST_POP_CAP;
      end

      ST_POP_CAP: begin
        now_d      = rdata.slot_time;
        pid_d      = rdata.slot_ident;
        ptime_d    = rdata.slot_time;
        reinsert_d = (rdata.slot_period != '0) && !next_time[64];
        new_d      = '{slot_time: next_time[63:0], slot_ident: rdata.slot_ident,
                       slot_period: rdata.slot_period};
        idx_d      = '0;
        state_d    = ST_SH_CHK;
      end

      ST_SH_CHK: begin
        // Close the gap at idx_q by pulling later slots down.
        if (idx_inc < count_q) begin
          raddr   = Aw'(idx_inc);
          state_d = ST_SH_WR;
        end else begin
          count_d = count_dec;
          if (is_pop_q && reinsert_q) begin
            if (count_dec == '0) begin
              state_d = ST_INS_PUT;
            end else begin
              idx_d   = Aw'(count_dec - Cw'(1));
              state_d = ST_INS_RD;
            end
          end else begin
            state_d = ST_FIN;
          end
        end
      end

      ST_SH_WR: begin
        we      = 1'b1;
        waddr   = idx_q;
        wdata   = rdata;
        idx_d   = Aw'(idx_inc);
        state_d = ST_SH_CHK;
      end

      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          rsp_d       = '{status: status_q, popped_id: pid_q, popped_time: ptime_q,
                          now_time: now_q};
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      now_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      now_q       <= now_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    new_q      <= new_d;
    idx_q      <= idx_d;
    status_q   <= status_d;
    pid_q      <= pid_d;
    ptime_q    <= ptime_d;
    reinsert_q <= reinsert_d;
    is_pop_q   <= is_pop_d;
    rsp_q      <= rsp_d;
  end

endmodule
